// ----- design/cpp_pkg.sv -----
// Shared types, constants and helpers for the camera point projection block.
package cpp_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam logic signed [15:0] CENTER_X = 16'(SCREEN_WIDTH / 2);
    localparam logic signed [15:0] CENTER_Y = 16'(SCREEN_HEIGHT / 2);

    localparam int XW = 36;       // yaw-rotated x and z
    localparam int ZW = 39;       // pitch-rotated y and depth
    localparam int NW = 56;       // numerator after fov scale
    localparam int QBITS = 17;    // quotient bits before saturation is certain
    localparam int DIV_STEPS = QBITS;

    typedef enum logic [2:0] {
        REG_CAMERA_X     = 3'd0,
        REG_CAMERA_Y     = 3'd1,
        REG_CAMERA_Z     = 3'd2,
        REG_YAW_COSINE   = 3'd3,
        REG_YAW_SINE     = 3'd4,
        REG_PITCH_COSINE = 3'd5,
        REG_PITCH_SINE   = 3'd6,
        REG_FIELD_OF_VIEW = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic signed [31:0] camera_z;
        logic signed [15:0] yaw_cosine;
        logic signed [15:0] yaw_sine;
        logic signed [15:0] pitch_cosine;
        logic signed [15:0] pitch_sine;
        logic [15:0]        field_of_view;
    } cfg_t;

    typedef struct packed {
        logic signed [XW-1:0] xr;
        logic signed [ZW-1:0] yr;
        logic signed [ZW-1:0] zp;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              neg_x;
        logic              neg_y;
        logic              ov_x;
        logic              ov_y;
        logic [NW-1:0]     rem_x;
        logic [NW-1:0]     rem_y;
        logic [QBITS-1:0]  quo_x;
        logic [QBITS-1:0]  quo_y;
        logic [ZW-1:0]     den;
    } div_t;

    function automatic logic signed [15:0] sat16(input logic signed [QBITS+2:0] v);
        logic signed [15:0] r;
        if (v > (QBITS+3)'(32767))
            r = 16'sh7fff;
        else if (v < -(QBITS+3)'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] place(
        input logic [QBITS-1:0] quo,
        input logic ov,
        input logic neg,
        input logic signed [15:0] center
    );
        logic [QBITS:0]            mag;
        logic signed [QBITS+2:0]   sv;
        mag = ov ? (QBITS+1)'(1) << QBITS : {1'b0, quo};
        sv  = neg ? -(QBITS+3)'(mag) : (QBITS+3)'(mag);
        return sat16(sv + (QBITS+3)'(center));
    endfunction

endpackage

// ----- design/camera_point_projection.sv -----
// Camera point projection: Q16.16 world point to saturated 16-bit screen coordinates.
// Input channel: in_valid/in_ready with point_x, point_y, point_z (signed Q16.16).
// Output channel: out_valid/out_ready with screen_x, screen_y and zero_depth.
// Configuration: cfg_write_en writes cfg_data into the register cfg_index selects
// (camera position, yaw/pitch cosine and sine in Q2.14, field of view); write only
// while no point is in flight.
// Throughput: one point per clock when the receiver keeps out_ready high.
// Pipeline: five rotation stages, the queue, fov multiply, abs, range check, 17 restoring
// divide steps (one quotient bit each) and the output register.
// A four-entry queue splits the rotation front from the divide back; when the
// receiver stalls, the back freezes, the queue fills, and then in_ready drops.
// Reset clears all valids and the queue and loads camera z = -5.0, both cosines
// = 1.0 and field of view = 320.
module camera_point_projection
    import cpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               zero_depth
);

    cfg_t  cfg_reg;
    logic  q_full, q_empty, q_push, q_pop;
    item_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x      <= '0;
            cfg_reg.camera_y      <= '0;
            cfg_reg.camera_z      <= 32'shfffb0000;
            cfg_reg.yaw_cosine    <= 16'sd16384;
            cfg_reg.yaw_sine      <= '0;
            cfg_reg.pitch_cosine  <= 16'sd16384;
            cfg_reg.pitch_sine    <= '0;
            cfg_reg.field_of_view <= 16'd320;
        end
        else if (cfg_write_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_CAMERA_X:      cfg_reg.camera_x      <= cfg_data;
                REG_CAMERA_Y:      cfg_reg.camera_y      <= cfg_data;
                REG_CAMERA_Z:      cfg_reg.camera_z      <= cfg_data;
                REG_YAW_COSINE:    cfg_reg.yaw_cosine    <= cfg_data[15:0];
                REG_YAW_SINE:      cfg_reg.yaw_sine      <= cfg_data[15:0];
                REG_PITCH_COSINE:  cfg_reg.pitch_cosine  <= cfg_data[15:0];
                REG_PITCH_SINE:    cfg_reg.pitch_sine    <= cfg_data[15:0];
                REG_FIELD_OF_VIEW: cfg_reg.field_of_view <= cfg_data[15:0];
                default:           cfg_reg.field_of_view <= cfg_reg.field_of_view;
            endcase
        end
    end

    cpp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    cpp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    cpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_item     (q_out),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .zero_depth (zero_depth)
    );

endmodule

// ----- design/cpp_front.sv -----
// Front pipeline: camera offset and yaw/pitch rotation, pushes items into the queue.
module cpp_front
    import cpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    logic [4:0] vld_reg;
    logic       en;

    logic signed [32:0]   dx_reg, dy_reg, dz_reg;
    logic signed [48:0]   p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [32:0]   dy2_reg, dy3_reg;
    logic signed [XW-1:0] xr_reg, zr_reg, xr4_reg, xr5_reg;
    logic signed [51:0]   q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [ZW-1:0] yr_reg, zp_reg;

    logic signed [49:0]   sum_x, sum_z;
    logic signed [52:0]   sum_y, sum_p;

    assign en       = !vld_reg[4] || !q_full;
    assign in_ready = en;
    assign q_push   = vld_reg[4] && !q_full;
    assign q_item   = '{xr: xr5_reg, yr: yr_reg, zp: zp_reg};

    assign sum_x = 50'(p1_reg) - 50'(p2_reg);
    assign sum_z = 50'(p3_reg) + 50'(p4_reg);
    assign sum_y = 53'(q1_reg) - 53'(q2_reg);
    assign sum_p = 53'(q3_reg) + 53'(q4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= 33'(point_x) - 33'(cfg.camera_x);
            dy_reg  <= 33'(point_y) - 33'(cfg.camera_y);
            dz_reg  <= 33'(point_z) - 33'(cfg.camera_z);

            p1_reg  <= dx_reg * cfg.yaw_cosine;
            p2_reg  <= dz_reg * cfg.yaw_sine;
            p3_reg  <= dz_reg * cfg.yaw_cosine;
            p4_reg  <= dx_reg * cfg.yaw_sine;
            dy2_reg <= dy_reg;

            xr_reg  <= XW'(sum_x >>> 14);
            zr_reg  <= XW'(sum_z >>> 14);
            dy3_reg <= dy2_reg;

            q1_reg  <= dy3_reg * cfg.pitch_cosine;
            q2_reg  <= zr_reg * cfg.pitch_sine;
            q3_reg  <= zr_reg * cfg.pitch_cosine;
            q4_reg  <= dy3_reg * cfg.pitch_sine;
            xr4_reg <= xr_reg;

            yr_reg  <= ZW'(sum_y >>> 14);
            zp_reg  <= ZW'(sum_p >>> 14);
            xr5_reg <= xr4_reg;
        end
    end

endmodule

// ----- design/cpp_fifo.sv -----
// Four-entry queue between the rotation front and the division back.
module cpp_fifo
    import cpp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t pop_item,
    output logic  full,
    output logic  empty
);

    item_t      mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign full     = count_reg == 3'd4;
    assign empty    = count_reg == 3'd0;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'd4)
        else $error("queue count out of range");
`endif

endmodule

// ----- design/cpp_back.sv -----
// Back pipeline: fov scale, pipelined restoring divide, centering and saturation; zero depth gives the centre.
module cpp_back
    import cpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    output logic               q_pop,
    input  item_t              q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               zero_depth
);

    logic en;

    logic                 b0_valid_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [ZW-1:0] zp_reg;

    div_t st_reg [DIV_STEPS+2];
    div_t st0_next, st1_next;

    logic               out_valid_reg;
    logic signed [15:0] screen_x_reg, screen_y_reg;
    logic               zero_depth_reg;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    assign out_valid  = out_valid_reg;
    assign screen_x   = screen_x_reg;
    assign screen_y   = screen_y_reg;
    assign zero_depth = zero_depth_reg;

    always_comb
    begin
        st0_next       = '0;
        st0_next.valid = b0_valid_reg;
        st0_next.zero  = zp_reg == '0;
        st0_next.neg_x = nx_reg[NW-1] ^ zp_reg[ZW-1];
        st0_next.neg_y = ny_reg[NW-1] ^ zp_reg[ZW-1];
        st0_next.rem_x = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        st0_next.rem_y = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        st0_next.den   = zp_reg[ZW-1] ? ZW'(-zp_reg) : ZW'(zp_reg);
    end

    always_comb
    begin
        st1_next      = st_reg[0];
        st1_next.ov_x = st_reg[0].rem_x >= (NW'(st_reg[0].den) << QBITS);
        st1_next.ov_y = st_reg[0].rem_y >= (NW'(st_reg[0].den) << QBITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg      <= 1'b0;
            st_reg[0].valid   <= 1'b0;
            st_reg[1].valid   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg  <= !q_empty;
            st_reg[0]     <= st0_next;
            st_reg[1]     <= st1_next;
            out_valid_reg <= st_reg[DIV_STEPS+1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= q_item.xr * $signed({1'b0, cfg.field_of_view});
            ny_reg <= q_item.yr * $signed({1'b0, cfg.field_of_view});
            zp_reg <= q_item.zp;
            if (st_reg[DIV_STEPS+1].zero)
            begin
                screen_x_reg   <= CENTER_X;
                screen_y_reg   <= CENTER_Y;
                zero_depth_reg <= 1'b1;
            end
            else
            begin
                screen_x_reg   <= place(st_reg[DIV_STEPS+1].quo_x, st_reg[DIV_STEPS+1].ov_x,
                                        st_reg[DIV_STEPS+1].neg_x, CENTER_X);
                screen_y_reg   <= place(st_reg[DIV_STEPS+1].quo_y, st_reg[DIV_STEPS+1].ov_y,
                                        st_reg[DIV_STEPS+1].neg_y, CENTER_Y);
                zero_depth_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        localparam int K = DIV_STEPS - 1 - i;
        div_t          nxt;
        logic [NW-1:0] sh;

        always_comb
        begin
            nxt = st_reg[i+1];
            sh  = NW'(st_reg[i+1].den) << K;
            if (st_reg[i+1].rem_x >= sh)
            begin
                nxt.rem_x    = st_reg[i+1].rem_x - sh;
                nxt.quo_x[K] = 1'b1;
            end
            if (st_reg[i+1].rem_y >= sh)
            begin
                nxt.rem_y    = st_reg[i+1].rem_y - sh;
                nxt.quo_y[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_reg[i+2].valid <= 1'b0;
            else if (en)
                st_reg[i+2] <= nxt;
        end
    end

`ifndef SYNTH
    a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_depth |-> screen_x == CENTER_X && screen_y == CENTER_Y)
        else $error("zero depth result not at screen center");
    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> b0_valid_reg)
        else $error("popped item lost");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(b0_valid_reg) && $stable(st_reg[DIV_STEPS+1].valid))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ----- verif/tb.sv -----
// Testbench for camera_point_projection: directed table plus random points, scoreboard check.
`timescale 1ns / 100ps

module tb
    import cpp_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               zero_depth;

    camera_point_projection dut (.*);

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               zd;
    } screen_pt_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               known;
        screen_pt_t         res;
    } dir_row_t;

    logic signed [31:0] cam_x, cam_y, cam_z;
    logic signed [15:0] yaw_c, yaw_s, pitch_c, pitch_s;
    logic [15:0]        fov;

    screen_pt_t pending_pts[$];
    int         mismatches;
    bit         stall_en;
    dir_row_t   dir_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint floor14(input longint v);
        return v >>> 14;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic screen_pt_t project_point(input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [31:0] pz);
        longint dx, dy, dz, xr, zr, yr, zp, f;
        screen_pt_t r;
        dx = longint'(px) - longint'(cam_x);
        dy = longint'(py) - longint'(cam_y);
        dz = longint'(pz) - longint'(cam_z);
        f  = longint'({1'b0, fov});
        xr = floor14(dx * yaw_c - dz * yaw_s);
        zr = floor14(dz * yaw_c + dx * yaw_s);
        yr = floor14(dy * pitch_c - zr * pitch_s);
        zp = floor14(zr * pitch_c + dy * pitch_s);
        if (zp == 0)
        begin
            r.sx = clamp16(SCREEN_WIDTH / 2);
            r.sy = clamp16(SCREEN_HEIGHT / 2);
            r.zd = 1'b1;
        end
        else
        begin
            r.sx = clamp16(SCREEN_WIDTH / 2 + (xr * f) / zp);
            r.sy = clamp16(SCREEN_HEIGHT / 2 + (yr * f) / zp);
            r.zd = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_CAMERA_X:     cam_x   = val;
            REG_CAMERA_Y:     cam_y   = val;
            REG_CAMERA_Z:     cam_z   = val;
            REG_YAW_COSINE:   yaw_c   = val[15:0];
            REG_YAW_SINE:     yaw_s   = val[15:0];
            REG_PITCH_COSINE: pitch_c = val[15:0];
            REG_PITCH_SINE:   pitch_s = val[15:0];
            default:          fov     = val[15:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        if (stall_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= px;
        point_y  <= py;
        point_z  <= pz;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pts.push_back(project_point(px, py, pz));
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic logic [15:0] rand_trig();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 16'h8000;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_CAMERA_X, $urandom_range(0, 3) == 0 ? $urandom : rand_coord());
        write_reg(REG_CAMERA_Y, rand_coord());
        write_reg(REG_CAMERA_Z, rand_coord());
        write_reg(REG_YAW_COSINE, rand_trig());
        write_reg(REG_YAW_SINE, rand_trig());
        write_reg(REG_PITCH_COSINE, rand_trig());
        write_reg(REG_PITCH_SINE, rand_trig());
        write_reg(REG_FIELD_OF_VIEW, $urandom_range(0, 2) == 0 ? 32'($urandom) : 32'(320));
    endtask

    // output side: random stall and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %0d %0d %0d",
                                 screen_x, screen_y, zero_depth);
                end
                else
                begin
                    screen_pt_t e;
                    e = pending_pts.pop_front();
                    if (e.sx !== screen_x || e.sy !== screen_y || e.zd !== zero_depth)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                     e.sx, e.sy, e.zd, screen_x, screen_y, zero_depth);
                    end
                end
            end
            out_ready <= !stall_en || ($urandom_range(0, 4) != 0);
        end
    end

    function automatic dir_row_t row(input logic signed [31:0] px, input logic signed [31:0] py,
                                     input logic signed [31:0] pz, input logic known,
                                     input logic signed [15:0] sx, input logic signed [15:0] sy,
                                     input logic zd);
        dir_row_t r;
        r.px = px; r.py = py; r.pz = pz; r.known = known;
        r.res.sx = sx; r.res.sy = sy; r.res.zd = zd;
        return r;
    endfunction

    initial
    begin
        screen_pt_t got;
        rst_n = 1'b0; cfg_write_en = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; point_x = '0; point_y = '0; point_z = '0; out_ready = 1'b1;
        cam_x = 0; cam_y = 0; cam_z = -327680;
        yaw_c = 16384; yaw_s = 0; pitch_c = 16384; pitch_s = 0; fov = 320;
        mismatches = 0; stall_en = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset camera: origin is 5 units ahead, centre; depth zero at camera plane
        dir_rows.push_back(row(0, 0, 0, 1, 320, 240, 0));
        dir_rows.push_back(row(0, 0, -327680, 1, 320, 240, 1));
        dir_rows.push_back(row(65536 * 5, 65536 * 5, 0, 1, 640, 560, 0));
        dir_rows.push_back(row(32'sh7fffffff, 0, -327679, 1, 32767, 240, 0));
        dir_rows.push_back(row(32'sh80000000, 32'sh80000000, -327679, 1,
                               -32768, -32768, 0));
        dir_rows.push_back(row(65536, 65536, -655360, 0, 0, 0, 0));
        dir_rows.push_back(row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0));
        dir_rows.push_back(row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0));
        dir_rows.push_back(row(-1, 1, 65536, 0, 0, 0, 0));
        foreach (dir_rows[i])
        begin
            got = project_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
            if (dir_rows[i].known && (got.sx !== dir_rows[i].res.sx ||
                                      got.sy !== dir_rows[i].res.sy ||
                                      got.zd !== dir_rows[i].res.zd))
            begin
                mismatches++;
                $display("table row %0d disagrees with predictor", i);
            end
            send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
        end
        drain();

        // extreme registers: fov max then zero, out-of-range trig
        write_reg(REG_FIELD_OF_VIEW, 32'hffff);
        write_reg(REG_YAW_SINE, 32'h8000);
        write_reg(REG_PITCH_SINE, 32'h7fff);
        write_reg(REG_CAMERA_X, 32'h80000000);
        for (int i = 0; i < 8; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        drain();
        write_reg(REG_FIELD_OF_VIEW, 0);
        write_reg(REG_YAW_COSINE, 32'h8000);
        write_reg(REG_PITCH_COSINE, 32'hc000);
        write_reg(REG_CAMERA_Y, 32'h7fffffff);
        write_reg(REG_CAMERA_Z, 32'h7fffffff);
        for (int i = 0; i < 6; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        drain();

        stall_en = 1'b1;
        for (int ph = 0; ph < 11; ph++)
        begin
            random_config();
            if (ph == 10)
                stall_en = 1'b0;
            for (int i = 0; i < 150; i++)
            begin
                if (i == 75 && ph == 3)
                begin
                    in_valid <= 1'b0;
                    while (pending_pts.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(0, 7) == 0)
                    send_point(cam_x, cam_y, cam_z);
                else
                    send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        if (mismatches == 0 && pending_pts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
